FILE: rtl/ciq_pkg.sv
// Shared types and constants for the coalescing input event queue.
`timescale 1ns / 1ps

package ciq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned REQ_W         = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 7;
    localparam int unsigned S_TDATA_W     = 224;
    localparam int unsigned M_TDATA_W     = 224;

    // most events one pop or peek returns
    localparam logic [COUNT_W-1:0] READ_CAP = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE_TAIL = 3'd0,
        REQ_WRITE_HEAD = 3'd1,
        REQ_POP        = 3'd2,
        REQ_PEEK       = 3'd3,
        REQ_FLUSH      = 3'd4,
        REQ_COUNT      = 3'd5
    } req_t;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [2:0]  EVT_KEY         = 3'd0;
    localparam logic [2:0]  EVT_MOUSE       = 3'd1;
    localparam logic [31:0] MOUSE_FLAG_MOVE = 32'd1;

    // one stored event record, event_type in the lowest bits
    typedef struct packed {
        logic [63:0] other_payload;
        logic [31:0] mouse_flags;
        logic [31:0] mouse_position;
        logic [31:0] control_state;
        logic [15:0] char_code;
        logic [15:0] scan_code;
        logic [15:0] repeat_count;
        logic        key_down;
        logic [2:0]  event_type;
    } event_rec_t;

    // request transaction data word
    typedef struct packed {
        logic [3:0]         pad;
        event_rec_t         rec;
        logic [COUNT_W-1:0] read_limit;
        logic               single_event;
    } s_data_t;

    // result transaction data word
    typedef struct packed {
        logic [4:0]         pad;
        event_rec_t         rec;
        logic [COUNT_W-1:0] event_count;
    } m_data_t;

endpackage

FILE: rtl/coalescing_input_event_queue.sv
// Coalescing input event queue: ring buffer of event records with a request sequencer.
`timescale 1ns / 1ps

// Double-ended ring queue of input event records, driven by one request per
// transaction on the s_ channel; results leave on the m_ channel.
//   s_tuser  : request code (write tail, write head, pop, peek, flush, count).
//   s_tdata  : single_event, read_limit, then the event record fields.
//   m_tuser  : status (ok, full, empty); m_tlast marks the final result.
//   m_tdata  : event_count, then the returned record (zero on non-read results).
// Requests are handled one at a time; s_tready is high only while the
// sequencer is idle. Record storage is one single-port-write RAM with a
// registered read, so every record read passes through the fetch state.
//   write, no merge attempt : accept, then write and result in ST_WRITE
//   write, merge attempt    : accept, neighbor fetch, then compare/update and result
//   pop/peek                : accept, then a fetch and an emit per returned event
//   flush, count, empty read: accept, then result in ST_REPLY
// The next request is taken the cycle after the final result is loaded into
// the output register, so a waiting result does not block acceptance.
// If the receiver stalls, the sequencer holds in place and the output
// register keeps its transaction. Reset empties the queue (pointers and
// occupancy cleared); RAM contents are left as they are.
module coalescing_input_event_queue #(
    parameter int unsigned QUEUE_DEPTH = ciq_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // single_event, read_limit, event_type, key_down, repeat_count, scan_code,
    // char_code, control_state, mouse_position, mouse_flags, other_payload
    input  logic [ciq_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic [ciq_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // event_count, out_event_type, out_key_down, out_repeat_count,
    // out_scan_code, out_char_code, out_control_state, out_mouse_position,
    // out_mouse_flags, out_other_payload
    output logic [ciq_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [ciq_pkg::STATUS_W-1:0]    m_tuser,
    output logic                            m_tlast
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W = (OCC_W > ciq_pkg::COUNT_W) ? OCC_W : ciq_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_REPLY = 5'b10000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    // record RAM
    ciq_pkg::event_rec_t mem [QUEUE_DEPTH];

    // control state
    state_t                           state_reg, state_next;
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [PTR_W-1:0]                 tail_reg, tail_next;
    logic [OCC_W-1:0]                 occ_reg, occ_next;
    logic [PTR_W-1:0]                 ptr_reg, ptr_next;      // RAM read address walker
    logic [ciq_pkg::COUNT_W-1:0]      n_reg, n_next;          // events to return
    logic [ciq_pkg::COUNT_W-1:0]      idx_reg, idx_next;      // events returned so far
    logic                             try_merge_reg, try_merge_next;
    logic                             m_valid_reg, m_valid_next;

    // request and result holding registers
    logic [ciq_pkg::REQ_W-1:0]        req_reg, req_next;
    ciq_pkg::s_data_t                 in_reg, in_next;
    logic [ciq_pkg::STATUS_W-1:0]     reply_status_reg, reply_status_next;
    logic [ciq_pkg::COUNT_W-1:0]      reply_count_reg, reply_count_next;
    ciq_pkg::event_rec_t              rd_data_reg;
    ciq_pkg::m_data_t                 m_data_reg;
    logic [ciq_pkg::STATUS_W-1:0]     m_status_reg;
    logic                             m_last_reg;

    // RAM write port and output load controls
    logic                             mem_we;
    logic [PTR_W-1:0]                 mem_waddr;
    ciq_pkg::event_rec_t              mem_wdata;
    logic                             load_out;
    logic [ciq_pkg::STATUS_W-1:0]     out_status;
    logic [ciq_pkg::COUNT_W-1:0]      out_count;
    logic                             out_last;
    ciq_pkg::event_rec_t              out_rec;

    ciq_pkg::s_data_t                 s_data;
    logic                             out_free;
    logic                             is_write_req;
    logic                             mouse_new, key_new, mouse_hit, key_hit, merge_hit;
    ciq_pkg::event_rec_t              merged_rec;
    logic [ciq_pkg::COUNT_W-1:0]      lim_capped;
    logic [ciq_pkg::COUNT_W-1:0]      n_calc;
    logic [ciq_pkg::COUNT_W-1:0]      idx_inc;
    logic                             emit_last;

    assign s_data   = ciq_pkg::s_data_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    assign is_write_req = (req_reg == ciq_pkg::REQ_WRITE_TAIL) ||
                          (req_reg == ciq_pkg::REQ_WRITE_HEAD);

    // merge compare against the fetched neighbor entry
    always_comb begin
        mouse_new = (in_reg.rec.event_type == ciq_pkg::EVT_MOUSE) &&
                    (in_reg.rec.mouse_flags == ciq_pkg::MOUSE_FLAG_MOVE);
        key_new   = (in_reg.rec.event_type == ciq_pkg::EVT_KEY) && in_reg.rec.key_down;
        mouse_hit = mouse_new &&
                    (rd_data_reg.event_type == ciq_pkg::EVT_MOUSE) &&
                    (rd_data_reg.mouse_flags == ciq_pkg::MOUSE_FLAG_MOVE);
        key_hit   = key_new &&
                    (rd_data_reg.event_type == ciq_pkg::EVT_KEY) &&
                    rd_data_reg.key_down &&
                    (rd_data_reg.scan_code == in_reg.rec.scan_code) &&
                    (rd_data_reg.char_code == in_reg.rec.char_code) &&
                    (rd_data_reg.control_state == in_reg.rec.control_state);
        merge_hit = try_merge_reg && (mouse_hit || key_hit);
        merged_rec = rd_data_reg;
        if (mouse_new) begin
            merged_rec.mouse_position = in_reg.rec.mouse_position;
        end else begin
            merged_rec.repeat_count = rd_data_reg.repeat_count + in_reg.rec.repeat_count;
        end
    end

    // read length: min(read_limit, cap, occupancy)
    always_comb begin
        lim_capped = (s_data.read_limit > ciq_pkg::READ_CAP) ? ciq_pkg::READ_CAP
                                                              : s_data.read_limit;
        if (CMP_W'(lim_capped) < CMP_W'(occ_reg)) begin
            n_calc = lim_capped;
        end else begin
            n_calc = ciq_pkg::COUNT_W'(occ_reg);
        end
    end

    assign idx_inc   = idx_reg + 7'd1;
    assign emit_last = (idx_inc == n_reg);

    // sequencer
    always_comb begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        occ_next          = occ_reg;
        ptr_next          = ptr_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        try_merge_next    = try_merge_reg;
        req_next          = req_reg;
        in_next           = in_reg;
        reply_status_next = reply_status_reg;
        reply_count_next  = reply_count_reg;
        mem_we            = 1'b0;
        mem_waddr         = ptr_reg;
        mem_wdata         = in_reg.rec;
        load_out          = 1'b0;
        out_status        = ciq_pkg::STAT_OK;
        out_count         = '0;
        out_last          = 1'b1;
        out_rec           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next          = s_tuser;
                    in_next           = s_data;
                    reply_status_next = ciq_pkg::STAT_OK;
                    reply_count_next  = '0;
                    state_next        = ST_REPLY;
                    unique case (s_tuser)
                        ciq_pkg::REQ_WRITE_TAIL, ciq_pkg::REQ_WRITE_HEAD: begin
                            try_merge_next = s_data.single_event && (occ_reg != '0);
                            ptr_next = (s_tuser == ciq_pkg::REQ_WRITE_TAIL) ?
                                       ptr_dec(tail_reg) : head_reg;
                            state_next = (s_data.single_event && (occ_reg != '0)) ?
                                         ST_FETCH : ST_WRITE;
                        end
                        ciq_pkg::REQ_POP, ciq_pkg::REQ_PEEK: begin
                            if (occ_reg == '0) begin
                                reply_status_next = ciq_pkg::STAT_EMPTY;
                            end else if (n_calc != '0) begin
                                n_next     = n_calc;
                                idx_next   = '0;
                                ptr_next   = head_reg;
                                state_next = ST_FETCH;
                            end
                        end
                        ciq_pkg::REQ_FLUSH: begin
                            head_next = '0;
                            tail_next = '0;
                            occ_next  = '0;
                        end
                        ciq_pkg::REQ_COUNT: begin
                            reply_count_next = ciq_pkg::COUNT_W'(occ_reg);
                        end
                        default: begin
                            // unused codes: plain success reply
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // RAM read of ptr_reg lands in rd_data_reg at this edge
                state_next = is_write_req ? ST_WRITE : ST_EMIT;
            end
            ST_WRITE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (merge_hit) begin
                        mem_we    = 1'b1;
                        mem_waddr = ptr_reg;
                        mem_wdata = merged_rec;
                        out_count = 7'd1;
                    end else if (occ_reg == OCC_FULL) begin
                        out_status = ciq_pkg::STAT_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        out_count = 7'd1;
                        occ_next  = occ_reg + OCC_W'(1);
                        if (req_reg == ciq_pkg::REQ_WRITE_TAIL) begin
                            mem_waddr = tail_reg;
                            tail_next = ptr_inc(tail_reg);
                        end else begin
                            mem_waddr = ptr_dec(head_reg);
                            head_next = ptr_dec(head_reg);
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    out_rec   = rd_data_reg;
                    out_count = idx_inc;
                    out_last  = emit_last;
                    ptr_next  = ptr_inc(ptr_reg);
                    idx_next  = idx_inc;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                        if (req_reg == ciq_pkg::REQ_POP) begin
                            head_next = ptr_inc(ptr_reg);
                            occ_next  = occ_reg - OCC_W'(n_reg);
                        end
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = reply_status_reg;
                    out_count  = reply_count_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            try_merge_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            ptr_reg       <= ptr_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            try_merge_reg <= try_merge_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        req_reg          <= req_next;
        in_reg           <= in_next;
        reply_status_reg <= reply_status_next;
        reply_count_reg  <= reply_count_next;
        if (load_out) begin
            m_data_reg.pad         <= '0;
            m_data_reg.rec         <= out_rec;
            m_data_reg.event_count <= out_count;
            m_status_reg           <= out_status;
            m_last_reg             <= out_last;
        end
    end

    // record RAM: one write port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // ring distance between the pointers, for checking against occupancy
    logic [OCC_W-1:0] ptr_gap;
    assign ptr_gap = OCC_W'(tail_reg) - OCC_W'(head_reg) +
                     ((tail_reg < head_reg) ? OCC_FULL : '0);

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_FULL)
        else $error("occupancy above queue depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_gap == ((occ_reg == OCC_FULL) ? '0 : occ_reg))
        else $error("head/tail pointers disagree with occupancy");

    a_peek_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && req_reg == ciq_pkg::REQ_PEEK) |=>
        ($stable(occ_reg) && $stable(head_reg)))
        else $error("peek changed the queue");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (idx_reg < n_reg))
        else $error("read index past read length");

endmodule
